@@ rtl/core/sha2h_pkg.sv @@
// shared types, constants and the rotate function of the sha-256/sha-224 hash unit
package sha2h_pkg;

    localparam int LengthBits = 61;
    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        t_st_idle,
        t_st_pad,
        t_st_len_hi,
        t_st_len_lo,
        t_st_round,
        t_st_fold,
        t_st_out
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load_iv;
        logic       push_in;
        logic       push_pad;
        logic       push_zero;
        logic       push_len_hi;
        logic       push_len_lo;
        logic       start_round;
        logic       do_round;
        logic       fold;
        logic       add_full;
        logic       add_part;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       block_full;
        logic       pos_is_14;
        logic       round_last;
    } t_sts;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] Init256 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] Init224 [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/core/sha2h_if.sv @@
// valid/ready channel interfaces for message words and digest words
interface sha2h_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
    modport source (output valid, data_word, byte_count, end_of_message, input ready);
    modport sink (input valid, data_word, byte_count, end_of_message, output ready);
endinterface

interface sha2h_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/core/sha256_sha224_hash_unit.sv @@
// top level of the sha-256/sha-224 streaming hash unit
// Takes one big-endian 32-bit message word per request; a word that fills a 16-word block
// is followed by 64 rounds of the shared round unit and one fold into the chain value.
// The end-of-message request pads in the block (pad, zero and length words, plus a
// second compression when the length does not fit), then presents 8 digest words
// (7 for sha-224) one per output request; no new word is taken until the last is read.
// Writing the mode abandons any message and reloads the initial chain value.
module sha256_sha224_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_wdata,
    sha2h_in_if.sink    i_in,
    sha2h_out_if.source o_out
);
    sha2h_pkg::t_cmd cmd;
    sha2h_pkg::t_sts sts;
    logic mode;
    logic [2:0] idx;

    sha2h_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we,
        .i_in_valid(i_in.valid), .i_eom(i_in.end_of_message),
        .i_byte_count(i_in.byte_count), .i_mode(mode), .i_out_ready(o_out.ready),
        .i_sts(sts), .o_in_ready(i_in.ready), .o_out_valid(o_out.valid),
        .o_out_index(idx), .o_out_last(o_out.last_word), .o_cmd(cmd)
    );

    sha2h_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_mode(i_cfg_wdata[0]),
        .i_data_word(i_in.data_word), .i_byte_count(i_in.byte_count),
        .i_out_index(idx), .i_cmd(cmd), .o_sts(sts), .o_mode(mode),
        .o_digest_word(o_out.digest_word)
    );

    assign o_out.word_index = idx;
endmodule

@@ rtl/core/sha2h_ctrl.sv @@
// controller state machine of the hash unit
module sha2h_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_in_valid,
    input  logic                i_eom,
    input  logic [2:0]          i_byte_count,
    input  logic                i_mode,
    input  logic                i_out_ready,
    input  sha2h_pkg::t_sts     i_sts,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output logic [2:0]          o_out_index,
    output logic                o_out_last,
    output sha2h_pkg::t_cmd     o_cmd
);
    sha2h_pkg::t_state r_state, n_state;
    sha2h_pkg::t_state r_ret, n_ret;   // where to go after a block compresses
    logic [2:0] r_idx, n_idx;
    logic       acc, take;

    assign acc  = i_in_valid && (r_state == sha2h_pkg::t_st_idle);
    assign take = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_idx   = r_idx;
        unique case (r_state)
            sha2h_pkg::t_st_idle: begin
                if (acc) begin
                    if (!i_eom) begin
                        n_ret = sha2h_pkg::t_st_idle;
                    end else if (i_byte_count >= 3'd4) begin
                        n_ret = sha2h_pkg::t_st_pad;
                    end else begin
                        n_ret = sha2h_pkg::t_st_len_hi;
                    end
                    if (i_sts.block_full) begin
                        n_state = sha2h_pkg::t_st_round;
                    end else begin
                        n_state = n_ret;
                    end
                end
            end
            sha2h_pkg::t_st_pad: begin
                n_ret = sha2h_pkg::t_st_len_hi;
                n_state = i_sts.block_full ? sha2h_pkg::t_st_round : sha2h_pkg::t_st_len_hi;
            end
            sha2h_pkg::t_st_len_hi: begin
                // zero fill until the length slot; a full block compresses on the way
                if (i_sts.pos_is_14) begin
                    n_state = sha2h_pkg::t_st_len_lo;
                end else if (i_sts.block_full) begin
                    n_ret = sha2h_pkg::t_st_len_hi;
                    n_state = sha2h_pkg::t_st_round;
                end
            end
            sha2h_pkg::t_st_len_lo: begin
                n_ret = sha2h_pkg::t_st_out;
                n_state = sha2h_pkg::t_st_round;
            end
            sha2h_pkg::t_st_round: begin
                if (i_sts.round_last) n_state = sha2h_pkg::t_st_fold;
            end
            sha2h_pkg::t_st_fold: begin
                n_state = r_ret;
                n_idx = 3'd0;
            end
            sha2h_pkg::t_st_out: begin
                if (take) begin
                    n_idx = r_idx + 3'd1;
                    if (o_out_last) n_state = sha2h_pkg::t_st_idle;
                end
            end
            default: n_state = sha2h_pkg::t_st_idle;
        endcase
        if (i_cfg_we) n_state = sha2h_pkg::t_st_idle;
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready  = (r_state == sha2h_pkg::t_st_idle);
        o_out_valid = (r_state == sha2h_pkg::t_st_out);
        o_out_index = r_idx;
        o_out_last  = (r_idx == (i_mode ? 3'd6 : 3'd7));
        o_cmd.load_iv = i_cfg_we || (take && o_out_last);
        unique case (r_state)
            sha2h_pkg::t_st_idle: begin
                o_cmd.push_in  = acc;
                o_cmd.add_full = acc && !i_eom;
                o_cmd.add_part = acc && i_eom;
                o_cmd.start_round = acc && i_sts.block_full;
            end
            sha2h_pkg::t_st_pad: begin
                o_cmd.push_pad = 1'b1;
                o_cmd.start_round = i_sts.block_full;
            end
            sha2h_pkg::t_st_len_hi: begin
                o_cmd.push_len_hi = i_sts.pos_is_14;
                o_cmd.push_zero   = !i_sts.pos_is_14;
                o_cmd.start_round = !i_sts.pos_is_14 && i_sts.block_full;
            end
            sha2h_pkg::t_st_len_lo: begin
                o_cmd.push_len_lo = 1'b1;
                o_cmd.start_round = 1'b1;
            end
            sha2h_pkg::t_st_round: o_cmd.do_round = 1'b1;
            sha2h_pkg::t_st_fold:  o_cmd.fold = 1'b1;
            sha2h_pkg::t_st_out:   ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha2h_pkg::t_st_idle;
            r_ret   <= sha2h_pkg::t_st_idle;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_idx   <= n_idx;
        end
    end

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("output and input open together");
    a_round_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha2h_pkg::t_st_round && i_sts.round_last && !i_cfg_we)
        |=> r_state == sha2h_pkg::t_st_fold) else $error("round end missed");
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> r_idx == 3'd0) else $error("digest not starting at zero");
endmodule

@@ rtl/core/sha2h_dp.sv @@
// datapath: chain value, working variables, schedule window and length
module sha2h_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_mode,
    input  logic [31:0]         i_data_word,
    input  logic [2:0]          i_byte_count,
    input  logic [2:0]          i_out_index,
    input  sha2h_pkg::t_cmd     i_cmd,
    output sha2h_pkg::t_sts     o_sts,
    output logic                o_mode,
    output logic [31:0]         o_digest_word
);
    localparam int Lb = sha2h_pkg::LengthBits;

    logic          r_mode;
    logic [31:0]   r_h [8];
    logic [31:0]   r_v [8];
    logic [31:0]   r_w [16];   // circular schedule window
    logic [3:0]    r_pos;
    logic [Lb-1:0] r_total, n_total;
    logic [5:0]    r_rnd;

    logic          push;
    logic [31:0]   push_w, kept, wnew, s0, s1, t1, t2, ww;
    logic [2:0]    bc;
    logic [Lb+2:0] bits;
    logic [Lb:0]   sum;
    logic [Lb-1:0] addn;

    assign o_mode = r_mode;
    assign o_digest_word = r_h[i_out_index];
    assign o_sts.block_full = (r_pos == 4'd15);
    assign o_sts.pos_is_14  = (r_pos == 4'd14);
    assign o_sts.round_last = (r_rnd == 6'd63);

    assign bc = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    assign bits = {r_total, 3'b000};

    always_comb begin
        kept = '0;
        unique case (bc)
            3'd1: kept = {i_data_word[31:24], sha2h_pkg::PadByte, 16'h0};
            3'd2: kept = {i_data_word[31:16], sha2h_pkg::PadByte, 8'h0};
            3'd3: kept = {i_data_word[31:8], sha2h_pkg::PadByte};
            3'd4: kept = i_data_word;
            default: kept = {sha2h_pkg::PadByte, 24'h0};
        endcase
        if (!i_cmd.add_part) kept = i_data_word;
    end

    always_comb begin
        push = i_cmd.push_in | i_cmd.push_pad | i_cmd.push_zero
             | i_cmd.push_len_hi | i_cmd.push_len_lo;
        push_w = kept;
        priority if (i_cmd.push_pad) push_w = {sha2h_pkg::PadByte, 24'h0};
        else if (i_cmd.push_zero) push_w = '0;
        else if (i_cmd.push_len_hi) push_w = 32'((bits >> 32));
        else if (i_cmd.push_len_lo) push_w = bits[31:0];
        else push_w = kept;
    end

    always_comb begin
        addn = i_cmd.add_part ? Lb'(bc) : Lb'(4);
        sum  = {1'b0, r_total} + {1'b0, addn};
        n_total = sum[Lb] ? {Lb{1'b1}} : sum[Lb-1:0];
    end

    // rounds 0..15 use the window as stored; later ones extend it in place
    always_comb begin
        s0 = sha2h_pkg::rotr(r_w[r_rnd[3:0] + 4'd1], 7) ^ sha2h_pkg::rotr(r_w[r_rnd[3:0] + 4'd1], 18)
           ^ (r_w[r_rnd[3:0] + 4'd1] >> 3);
        s1 = sha2h_pkg::rotr(r_w[r_rnd[3:0] + 4'd14], 17) ^ sha2h_pkg::rotr(r_w[r_rnd[3:0] + 4'd14], 19)
           ^ (r_w[r_rnd[3:0] + 4'd14] >> 10);
        wnew = r_w[r_rnd[3:0]] + s0 + r_w[r_rnd[3:0] + 4'd9] + s1;
        ww = (r_rnd < 6'd16) ? r_w[r_rnd[3:0]] : wnew;
        t1 = r_v[7] + (sha2h_pkg::rotr(r_v[4], 6) ^ sha2h_pkg::rotr(r_v[4], 11)
           ^ sha2h_pkg::rotr(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + sha2h_pkg::RoundK[r_rnd] + ww;
        t2 = (sha2h_pkg::rotr(r_v[0], 2) ^ sha2h_pkg::rotr(r_v[0], 13)
           ^ sha2h_pkg::rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (push) r_w[r_pos] <= push_w;
        else if (i_cmd.do_round && r_rnd >= 6'd16) r_w[r_rnd[3:0]] <= wnew;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_pos <= '0;
            r_total <= '0;
            r_rnd <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha2h_pkg::Init256[i];
                r_v[i] <= '0;
            end
        end else begin
            if (push) r_pos <= r_pos + 4'd1;
            if (i_cmd.add_full || i_cmd.add_part) r_total <= n_total;
            if (i_cmd.start_round) begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                r_rnd <= '0;
            end else if (i_cmd.do_round) begin
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd <= r_rnd + 6'd1;
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cfg_we) r_mode <= i_cfg_mode;
            if (i_cmd.load_iv) begin
                for (int i = 0; i < 8; i++)
                    r_h[i] <= (i_cfg_we ? i_cfg_mode : r_mode)
                        ? sha2h_pkg::Init224[i] : sha2h_pkg::Init256[i];
                r_pos <= '0;
                r_total <= '0;
            end
        end
    end

    a_rnd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.do_round && !i_cmd.start_round |=> $stable(r_rnd))
        else $error("round counter moved outside compression");
    a_no_push_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_round |-> !push) else $error("window written during rounds");
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_round |-> r_pos == 4'd15) else $error("compression without full block");
endmodule
